// ===== hw/rtl/tkc_pkg.sv =====
// Shared types and constants of the tiered keyword counter.
// Used by tkc_cell and tiered_keyword_counter; depends on nothing.
package tkc_pkg;

  localparam int unsigned TIERS     = 3;
  localparam int unsigned ENTRIES   = 64;
  localparam int unsigned SLOT_W    = 6;
  localparam int unsigned MAX_WORD  = 16;
  localparam int unsigned LEN_W     = 5;
  localparam int unsigned COUNT_W   = 32;
  localparam int unsigned CHUNK_W   = 64;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(ENTRIES - 1);

  typedef enum logic [1:0] {
    KIND_TEXT  = 2'd0,
    KIND_LOAD  = 2'd1,
    KIND_QUERY = 2'd2,
    KIND_NONE  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    OP_SEARCH = 2'd0,
    OP_LOAD   = 2'd1,
    OP_QUERY  = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    C_IDLE,
    C_SCAN,
    C_LAST,
    C_READ,
    C_BUMP,
    C_QREAD
  } cell_st_e;

  typedef enum logic [1:0] {
    T_IDLE,
    T_WAIT,
    T_PUSH
  } top_st_e;

  // Command handed from cell to cell
  typedef struct packed {
    logic               valid;
    op_e                op;
    logic [1:0]         level;
    logic [SLOT_W-1:0]  slot;
    logic               csel;
    logic [CHUNK_W-1:0] bytes;
    logic [LEN_W-1:0]   elen;
  } cmd_t;

  // Current word, shared by all cells
  typedef struct packed {
    logic [LEN_W-1:0]            len;
    logic [MAX_WORD-1:0][7:0]    chars;
  } word_t;

  // Status of one cell back to the top level
  typedef struct packed {
    logic               busy;
    logic               hit;
    logic [COUNT_W-1:0] entry_hits;
    logic [COUNT_W-1:0] total;
  } stat_t;

  // Pending result
  typedef struct packed {
    logic               kind;
    logic [TIERS-1:0]   hits;
    logic               too_long;
    logic [COUNT_W-1:0] entry_hits;
    logic [COUNT_W-1:0] total;
  } res_t;

endpackage

// ===== hw/rtl/tkc_cell.sv =====
// One keyword table of the tiered keyword counter, a link of the command chain.
// Holds the table's text, lengths, counts and total. Depends on tkc_pkg.
module tkc_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [1:0]     tier_i,
  input  tkc_pkg::cmd_t  cmd_i,
  input  tkc_pkg::word_t word_i,
  output tkc_pkg::cmd_t  cmd_o,
  output tkc_pkg::stat_t stat_o
);

  tkc_pkg::cell_st_e state_q, state_d;
  tkc_pkg::cmd_t     cmd_q;

  logic [tkc_pkg::CHUNK_W-1:0] text0_mem [tkc_pkg::ENTRIES];
  logic [tkc_pkg::CHUNK_W-1:0] text1_mem [tkc_pkg::ENTRIES];
  logic [tkc_pkg::LEN_W-1:0]   len_mem   [tkc_pkg::ENTRIES];
  logic [tkc_pkg::COUNT_W-1:0] hits_mem  [tkc_pkg::ENTRIES];
  logic [tkc_pkg::ENTRIES-1:0] valid_q;

  logic [tkc_pkg::CHUNK_W-1:0] text0_rd_q, text1_rd_q;
  logic [tkc_pkg::LEN_W-1:0]   len_rd_q;
  logic [tkc_pkg::COUNT_W-1:0] hits_rd_q;

  logic [tkc_pkg::SLOT_W-1:0]  scan_q, cmp_slot_q, fslot_q;
  logic                        cmp_v_q, rd_valid_q, found_q, hit_q, qv_q;
  logic [tkc_pkg::COUNT_W-1:0] total_q;

  logic                        mine, do_load, do_search, do_query;
  logic                        scan_rd, hits_re, hits_we, bump;
  logic [tkc_pkg::SLOT_W-1:0]  hits_ra, hits_wa;
  logic [tkc_pkg::COUNT_W-1:0] hits_wd;
  logic                        match, found_any;
  logic [tkc_pkg::MAX_WORD-1:0] byte_eq;

  function automatic logic [tkc_pkg::LEN_W-1:0] LEN_W_ext(input int unsigned v);
    return tkc_pkg::LEN_W'(v);
  endfunction

  assign mine      = cmd_i.valid && (cmd_i.level == tier_i);
  assign do_load   = mine && (cmd_i.op == tkc_pkg::OP_LOAD);
  assign do_query  = mine && (cmd_i.op == tkc_pkg::OP_QUERY) && (state_q == tkc_pkg::C_IDLE);
  assign do_search = cmd_i.valid && (cmd_i.op == tkc_pkg::OP_SEARCH)
                     && (state_q == tkc_pkg::C_IDLE);

  // Compare the entry read last cycle with the word
  always_comb begin
    for (int i = 0; i < tkc_pkg::MAX_WORD; i++) begin
      if (i < 8) begin
        byte_eq[i] = (LEN_W_ext(i) >= len_rd_q)
                     || (text0_rd_q[8*i +: 8] == word_i.chars[i]);
      end else begin
        byte_eq[i] = (LEN_W_ext(i) >= len_rd_q)
                     || (text1_rd_q[8*(i-8) +: 8] == word_i.chars[i]);
      end
    end
  end

  assign match = cmp_v_q && rd_valid_q && (len_rd_q != '0) && (len_rd_q == word_i.len)
                 && (len_rd_q <= tkc_pkg::LEN_W'(tkc_pkg::MAX_WORD)) && (&byte_eq);
  assign found_any = found_q || match;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tkc_pkg::C_IDLE: begin
        if (do_search) state_d = tkc_pkg::C_SCAN;
        else if (do_query) state_d = tkc_pkg::C_QREAD;
      end
      tkc_pkg::C_SCAN: begin
        if (scan_q == tkc_pkg::LAST_SLOT) state_d = tkc_pkg::C_LAST;
      end
      tkc_pkg::C_LAST: state_d = found_any ? tkc_pkg::C_READ : tkc_pkg::C_IDLE;
      tkc_pkg::C_READ: state_d = tkc_pkg::C_BUMP;
      tkc_pkg::C_BUMP: state_d = tkc_pkg::C_IDLE;
      tkc_pkg::C_QREAD: state_d = tkc_pkg::C_IDLE;
      default: state_d = tkc_pkg::C_IDLE;
    endcase
  end

  // Memory port control
  always_comb begin
    scan_rd = 1'b0;
    hits_re = 1'b0;
    hits_ra = cmd_i.slot;
    bump    = 1'b0;
    unique case (state_q)
      tkc_pkg::C_IDLE: hits_re = do_query;
      tkc_pkg::C_SCAN: scan_rd = 1'b1;
      tkc_pkg::C_READ: begin
        hits_re = 1'b1;
        hits_ra = fslot_q;
      end
      tkc_pkg::C_BUMP: bump = 1'b1;
      default: ;
    endcase
    hits_we = do_load || bump;
    hits_wa = bump ? fslot_q : cmd_i.slot;
    hits_wd = '0;
    if (bump) hits_wd = (&hits_rd_q) ? hits_rd_q : hits_rd_q + 1'b1;
  end

  // Table memories
  always_ff @(posedge clk_i) begin
    if (do_load) begin
      if (cmd_i.csel) text1_mem[cmd_i.slot] <= cmd_i.bytes;
      else            text0_mem[cmd_i.slot] <= cmd_i.bytes;
      len_mem[cmd_i.slot] <= cmd_i.elen;
    end
    if (scan_rd) begin
      text0_rd_q <= text0_mem[scan_q];
      text1_rd_q <= text1_mem[scan_q];
      len_rd_q   <= len_mem[scan_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (hits_we) hits_mem[hits_wa] <= hits_wd;
    if (hits_re) hits_rd_q <= hits_mem[hits_ra];
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= tkc_pkg::C_IDLE;
      cmd_q      <= '0;
      valid_q    <= '0;
      scan_q     <= '0;
      cmp_slot_q <= '0;
      fslot_q    <= '0;
      cmp_v_q    <= 1'b0;
      rd_valid_q <= 1'b0;
      found_q    <= 1'b0;
      hit_q      <= 1'b0;
      qv_q       <= 1'b0;
      total_q    <= '0;
    end else begin
      state_q <= state_d;
      cmd_q   <= cmd_i;
      if (do_load) valid_q[cmd_i.slot] <= 1'b1;
      cmp_v_q <= scan_rd;
      if (scan_rd) begin
        rd_valid_q <= valid_q[scan_q];
        cmp_slot_q <= scan_q;
        scan_q     <= scan_q + 1'b1;
      end
      if (do_search) begin
        scan_q  <= '0;
        found_q <= 1'b0;
        hit_q   <= 1'b0;
      end else if (match && !found_q) begin
        found_q <= 1'b1;
        fslot_q <= cmp_slot_q;
      end
      if (bump) begin
        hit_q   <= 1'b1;
        total_q <= (&total_q) ? total_q : total_q + 1'b1;
      end
      if (do_query) qv_q <= valid_q[cmd_i.slot];
    end
  end

  assign cmd_o             = cmd_q;
  assign stat_o.busy       = (state_q != tkc_pkg::C_IDLE);
  assign stat_o.hit        = hit_q;
  assign stat_o.entry_hits = qv_q ? hits_rd_q : '0;
  assign stat_o.total      = total_q;

endmodule

// ===== hw/rtl/tiered_keyword_counter.sv =====
// Top level of the tiered keyword counter: word builder, control and cell chain.
// Depends on tkc_pkg and tkc_cell.
//
// Usage: items enter on the in channel (in_valid_i / in_stall_o), results leave
// on the out channel (out_valid_o / out_stall_i); a transfer happens on a clock
// edge with valid high and stall low. min_word_len is written through cfg_we_i.
// A text byte that is a letter or digit, or is ignored, is taken without
// leaving the idle state. A word end that is not checked clears the word and
// also stays idle; a too-long word goes straight on to the output transfer.
// A checked word is searched in all three tables as the command passes down
// the chain, one entry per table per cycle: 64 entry reads of each table memory
// plus chain travel through three cells and the count update.
// Loads and queries of a table level pass through the three cells of the chain;
// a query also waits for the count read in the addressed cell.
// Only one item is worked on at a time; the next item is taken once the
// result of the previous one sits in the output register.
// Reset clears all totals, marks every entry unloaded (a load clears its count)
// and sets min_word_len to 3. A stalled receiver holds the result in the output
// register; the block holds the following result until that one is taken.
module tiered_keyword_counter (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [4:0]                  cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [1:0]                  kind_i,
  input  logic [7:0]                  text_byte_i,
  input  logic [1:0]                  level_i,
  input  logic [5:0]                  entry_slot_i,
  input  logic                        chunk_select_i,
  input  logic [63:0]                 chunk_bytes_i,
  input  logic [4:0]                  entry_length_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        result_kind_o,
  output logic                        hit_high_o,
  output logic                        hit_medium_o,
  output logic                        hit_low_o,
  output logic                        word_too_long_o,
  output logic [31:0]                 entry_hits_o,
  output logic [31:0]                 table_total_o
);

  tkc_pkg::top_st_e state_q, state_d;

  logic [4:0]                  min_len_q;
  logic [tkc_pkg::LEN_W-1:0]   word_len_q;
  logic                        word_ovf_q;
  logic [tkc_pkg::MAX_WORD-1:0][7:0] word_chars_q;
  tkc_pkg::cmd_t               issue_q, issue_d;
  tkc_pkg::res_t               res_q, res_d;
  logic [1:0]                  level_q;
  logic                        tail_seen_q;
  tkc_pkg::res_t               out_q;
  logic                        out_valid_q;

  tkc_pkg::cmd_t  chain [tkc_pkg::TIERS+1];
  tkc_pkg::stat_t stat  [tkc_pkg::TIERS];
  tkc_pkg::word_t word;

  logic accept, is_alnum, ignored, checked, any_busy, tail_now, wait_done;
  logic take_out, load_out, append, clear_word;
  logic [tkc_pkg::LEN_W-1:0] eff_len;

  assign accept   = in_valid_i && !in_stall_o;
  assign is_alnum = (text_byte_i >= 8'h30 && text_byte_i <= 8'h39)
                 || (text_byte_i >= 8'h41 && text_byte_i <= 8'h5A)
                 || (text_byte_i >= 8'h61 && text_byte_i <= 8'h7A);
  assign ignored  = (text_byte_i == 8'h00) || text_byte_i[7];
  assign eff_len  = word_ovf_q ? tkc_pkg::LEN_W'(tkc_pkg::MAX_WORD + 1) : word_len_q;
  assign checked  = eff_len > min_len_q;

  assign any_busy  = stat[0].busy || stat[1].busy || stat[2].busy;
  assign tail_now  = chain[tkc_pkg::TIERS].valid;
  assign wait_done = (tail_now || tail_seen_q) && !any_busy;
  assign take_out  = out_valid_q && !out_stall_i;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tkc_pkg::T_IDLE: begin
        if (accept) begin
          case (kind_i)
            tkc_pkg::KIND_TEXT: begin
              if (!ignored && !is_alnum && checked) begin
                state_d = word_ovf_q ? tkc_pkg::T_PUSH : tkc_pkg::T_WAIT;
              end
            end
            tkc_pkg::KIND_LOAD: state_d = tkc_pkg::T_WAIT;
            tkc_pkg::KIND_QUERY: begin
              state_d = (level_i < 2'(tkc_pkg::TIERS)) ? tkc_pkg::T_WAIT : tkc_pkg::T_PUSH;
            end
            default: ;
          endcase
        end
      end
      tkc_pkg::T_WAIT: begin
        if (wait_done) state_d = issue_q.op == tkc_pkg::OP_LOAD ? tkc_pkg::T_IDLE
                                                                : tkc_pkg::T_PUSH;
      end
      tkc_pkg::T_PUSH: begin
        if (!out_valid_q || !out_stall_i) state_d = tkc_pkg::T_IDLE;
      end
      default: state_d = tkc_pkg::T_IDLE;
    endcase
  end

  // Commands, pending result and word update
  always_comb begin
    issue_d       = issue_q;
    issue_d.valid = 1'b0;
    res_d         = res_q;
    append        = 1'b0;
    clear_word    = 1'b0;
    load_out      = 1'b0;
    unique case (state_q)
      tkc_pkg::T_IDLE: begin
        if (accept) begin
          issue_d.level = level_i;
          issue_d.slot  = entry_slot_i;
          issue_d.csel  = chunk_select_i;
          issue_d.bytes = chunk_bytes_i;
          issue_d.elen  = entry_length_i;
          res_d         = '0;
          case (kind_i)
            tkc_pkg::KIND_TEXT: begin
              if (!ignored) begin
                if (is_alnum) begin
                  append = 1'b1;
                end else if (checked && !word_ovf_q) begin
                  issue_d.valid = 1'b1;
                  issue_d.op    = tkc_pkg::OP_SEARCH;
                end else begin
                  res_d.too_long = word_ovf_q;
                  clear_word     = 1'b1;
                end
              end
            end
            tkc_pkg::KIND_LOAD: begin
              issue_d.valid = 1'b1;
              issue_d.op    = tkc_pkg::OP_LOAD;
            end
            tkc_pkg::KIND_QUERY: begin
              res_d.kind    = 1'b1;
              issue_d.valid = level_i < 2'(tkc_pkg::TIERS);
              issue_d.op    = tkc_pkg::OP_QUERY;
            end
            default: ;
          endcase
        end
      end
      tkc_pkg::T_WAIT: begin
        if (wait_done) begin
          if (issue_q.op == tkc_pkg::OP_SEARCH) begin
            res_d.hits = {stat[2].hit, stat[1].hit, stat[0].hit};
            clear_word = 1'b1;
          end else if (issue_q.op == tkc_pkg::OP_QUERY) begin
            case (level_q)
              2'd0: begin
                res_d.entry_hits = stat[0].entry_hits;
                res_d.total      = stat[0].total;
              end
              2'd1: begin
                res_d.entry_hits = stat[1].entry_hits;
                res_d.total      = stat[1].total;
              end
              2'd2: begin
                res_d.entry_hits = stat[2].entry_hits;
                res_d.total      = stat[2].total;
              end
              default: ;
            endcase
          end
        end
      end
      tkc_pkg::T_PUSH: load_out = !out_valid_q || !out_stall_i;
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tkc_pkg::T_IDLE;
      min_len_q   <= 5'd3;
      word_len_q  <= '0;
      word_ovf_q  <= 1'b0;
      issue_q     <= '0;
      res_q       <= '0;
      level_q     <= '0;
      tail_seen_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      issue_q <= issue_d;
      res_q   <= res_d;
      if (cfg_we_i) min_len_q <= cfg_wdata_i;
      if (accept) level_q <= level_i;
      if (issue_d.valid) tail_seen_q <= 1'b0;
      else if (tail_now) tail_seen_q <= 1'b1;
      if (clear_word) begin
        word_len_q <= '0;
        word_ovf_q <= 1'b0;
      end else if (append) begin
        if (word_len_q < tkc_pkg::LEN_W'(tkc_pkg::MAX_WORD)) word_len_q <= word_len_q + 1'b1;
        else word_ovf_q <= 1'b1;
      end
      if (load_out) out_valid_q <= 1'b1;
      else if (take_out) out_valid_q <= 1'b0;
    end
  end

  // Word characters and output payload
  always_ff @(posedge clk_i) begin
    if (append && word_len_q < tkc_pkg::LEN_W'(tkc_pkg::MAX_WORD)) begin
      word_chars_q[word_len_q[3:0]] <= text_byte_i;
    end
    if (load_out) out_q <= res_q;
  end

  assign word.len   = word_len_q;
  assign word.chars = word_chars_q;
  assign chain[0]   = issue_q;

  // Cell chain, one cell per table
  for (genvar g = 0; g < tkc_pkg::TIERS; g++) begin : g_cell
    tkc_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .tier_i (2'(g)),
      .cmd_i  (chain[g]),
      .word_i (word),
      .cmd_o  (chain[g+1]),
      .stat_o (stat[g])
    );
  end

  assign in_stall_o      = (state_q != tkc_pkg::T_IDLE);
  assign out_valid_o     = out_valid_q;
  assign result_kind_o   = out_q.kind;
  assign hit_high_o      = out_q.hits[0];
  assign hit_medium_o    = out_q.hits[1];
  assign hit_low_o       = out_q.hits[2];
  assign word_too_long_o = out_q.too_long;
  assign entry_hits_o    = out_q.entry_hits;
  assign table_total_o   = out_q.total;

endmodule

// ===== hw/rtl/tkc_checker.sv =====
// Port-level checks of the tiered keyword counter, bound to the top level.
// Depends on tiered_keyword_counter's ports only.
module tkc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        result_kind_o,
  input logic        hit_high_o,
  input logic        hit_medium_o,
  input logic        hit_low_o,
  input logic        word_too_long_o,
  input logic [31:0] entry_hits_o,
  input logic [31:0] table_total_o
);

  // Query replies carry no word flags
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && result_kind_o |-> !hit_high_o && !hit_medium_o && !hit_low_o
                                     && !word_too_long_o)
    else $error("query reply carries word flags");

  // Word results carry no counts
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !result_kind_o |-> entry_hits_o == 32'd0 && table_total_o == 32'd0)
    else $error("word result carries counts");

  // A too-long word matches nothing
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && word_too_long_o |-> !hit_high_o && !hit_medium_o && !hit_low_o)
    else $error("too-long word reported a hit");

  // Stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(entry_hits_o)
                                   && $stable(table_total_o))
    else $error("stalled result changed");

endmodule

bind tiered_keyword_counter tkc_checker u_tkc_checker (.*);
